FILE: hdl/assert_macros.svh
// Assertion macros shared by the RTL files of the ordered integer set table.
// Depends on nothing; the SYNTH macro selects empty bodies for synthesis.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// Same-cycle implication, disabled during reset.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("implication check failed");
// Next-cycle implication, disabled during reset.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle check failed");
`else
`define ASSERT_IMPLIES(label, clk, rst, ante, cons)
`define ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

FILE: hdl/oist_pkg.sv
// Package of the ordered integer set table: capacity, widths, codes and types.
// Depends on nothing; used by the cell and the top level.
`default_nettype none
package oist_pkg;

  localparam int CAPACITY = 64;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int POS_W    = 6;
  localparam int CMP_W    = (CNT_W > POS_W) ? CNT_W : POS_W;

  typedef enum logic [2:0] {
    OP_ADD      = 3'd0,
    OP_CONTAINS = 3'd1,
    OP_REMOVE   = 3'd2,
    OP_GET      = 3'd3,
    OP_LENGTH   = 3'd4,
    OP_CLEAR    = 3'd5
  } op_t;

  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_FULL  = 2'd1,
    STAT_RANGE = 2'd2
  } status_t;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_EXEC = 1'b1
  } state_t;

  // Broadcast control from the sequencer to every cell of the row.
  typedef struct packed {
    logic        capture;
    logic [31:0] key;
    logic        add_go;
    logic        remove_go;
    logic        clear_go;
  } cell_ctrl_t;

endpackage
`default_nettype wire

FILE: hdl/oist_req_if.sv
// Request channel of the ordered integer set table: valid/ready plus operation.
// Depends on nothing.
`default_nettype none
interface oist_req_if;
  logic               valid;
  logic               ready;
  logic [2:0]         op;
  logic signed [31:0] key_value;
  logic [5:0]         position;

  modport source (output valid, op, key_value, position, input ready);
  modport sink   (input valid, op, key_value, position, output ready);
endinterface
`default_nettype wire

FILE: hdl/oist_rsp_if.sv
// Response channel of the ordered integer set table: valid/ready plus result.
// Depends on nothing.
`default_nettype none
interface oist_rsp_if;
  logic               valid;
  logic               ready;
  logic               hit;
  logic signed [31:0] read_value;
  logic [6:0]         count;
  logic [1:0]         status;

  modport source (output valid, hit, read_value, count, status, input ready);
  modport sink   (input valid, hit, read_value, count, status, output ready);
endinterface
`default_nettype wire

FILE: hdl/oist_cell.sv
// One cell of the set table row: holds one entry, its occupied flag and match.
// Depends on oist_pkg.
`default_nettype none
module oist_cell (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire oist_pkg::cell_ctrl_t ctrl,
  input  wire logic               prev_occ,
  input  wire logic               seen_in,
  input  wire logic               next_occ,
  input  wire logic [31:0]        next_value,
  output logic [31:0]             value,
  output logic                    occ,
  output logic                    seen_out
);
  import oist_pkg::*;

  logic match;
  logic add_here;
  logic shift_here;

  // The first free cell is the one whose left neighbor is occupied.
  assign add_here   = ctrl.add_go && prev_occ && !occ;
  assign seen_out   = seen_in | match;
  assign shift_here = ctrl.remove_go && seen_out;

  always_ff @(posedge clk) begin
    if (shift_here) begin
      value <= next_value;
    end else if (add_here) begin
      value <= ctrl.key;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      occ   <= 1'b0;
      match <= 1'b0;
    end else begin
      if (ctrl.capture) begin
        match <= occ && (value == ctrl.key);
      end
      if (ctrl.clear_go) begin
        occ <= 1'b0;
      end else if (shift_here) begin
        occ <= next_occ;
      end else if (add_here) begin
        occ <= 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

FILE: hdl/ordered_integer_set_table.sv
// Ordered integer set table: keeps up to CAPACITY distinct 32-bit integers in
// the order they were added, in a row of cells with one entry each. Every
// request transfer passes through the IDLE and EXEC states: in IDLE, as it is
// taken, the key is compared in all cells at once and each cell registers its
// match; in EXEC a match flag ripples along the row, the cells at and after a
// removed entry take their right neighbor's entry, a new entry is written into
// the first free cell, and the response is loaded into the output register.
// The next request is taken once the previous response transfer has completed
// or completes in the same cycle, and only when idle, so a new request is not
// taken before the previous one has been through EXEC. No clearing pass runs
// after reset: cells carry an occupied flag, and entry storage is undefined
// until written.
// Depends on oist_pkg, oist_req_if, oist_rsp_if, oist_cell and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"
module ordered_integer_set_table (
  input  wire logic clk,
  input  wire logic rst,
  oist_req_if.sink   req,
  oist_rsp_if.source rsp
);
  import oist_pkg::*;

  state_t           state;
  state_t           state_next;
  logic             req_fire;
  logic [2:0]       op_q;
  logic [31:0]      key_q;
  logic [POS_W-1:0] pos_q;
  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] count_next;

  cell_ctrl_t       ctrl;
  logic [31:0]      cell_value [CAPACITY];
  logic [CAPACITY-1:0] cell_occ;
  logic [CAPACITY-1:0] seen;
  logic             any_match;
  logic             full;
  logic             in_range;
  logic [IDX_W-1:0] rd_idx;

  logic             res_hit;
  logic [31:0]      res_value;
  logic [6:0]       res_count;
  status_t          res_status;
  logic             load_rsp;

  // A request is taken only when idle and the output register is free or
  // emptying in this cycle.
  assign req.ready = (state == ST_IDLE) && (!rsp.valid || rsp.ready);
  assign req_fire  = req.valid && req.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (req_fire) begin
      op_q  <= req.op;
      key_q <= $unsigned(req.key_value);
      pos_q <= req.position;
    end
  end

  // The row of cells; the match flag travels left to right and entries move
  // right to left on removal.
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    oist_cell u_cell (
      .clk        (clk),
      .rst        (rst),
      .ctrl       (ctrl),
      .prev_occ   ((i == 0) ? 1'b1 : cell_occ[(i == 0) ? 0 : i - 1]),
      .seen_in    ((i == 0) ? 1'b0 : seen[(i == 0) ? 0 : i - 1]),
      .next_occ   ((i == CAPACITY - 1) ? 1'b0 :
                   cell_occ[(i == CAPACITY - 1) ? i : i + 1]),
      .next_value ((i == CAPACITY - 1) ? 32'd0 :
                   cell_value[(i == CAPACITY - 1) ? i : i + 1]),
      .value      (cell_value[i]),
      .occ        (cell_occ[i]),
      .seen_out   (seen[i])
    );
  end

  assign any_match = seen[CAPACITY-1];
  assign full      = (count == CNT_W'(CAPACITY));
  assign in_range  = (CMP_W'(pos_q) < CMP_W'(count));
  assign rd_idx    = IDX_W'(pos_q);

  // Sequencer: next state, cell control and the response of the EXEC state.
  always_comb begin
    state_next     = state;
    ctrl.capture   = 1'b0;
    ctrl.key       = (state == ST_IDLE) ? $unsigned(req.key_value) : key_q;
    ctrl.add_go    = 1'b0;
    ctrl.remove_go = 1'b0;
    ctrl.clear_go  = 1'b0;
    count_next     = count;
    res_hit        = 1'b0;
    res_value      = 32'd0;
    res_count      = 7'(count);
    res_status     = STAT_OK;
    load_rsp       = 1'b0;
    case (state)
      ST_IDLE: begin
        if (req_fire) begin
          ctrl.capture = 1'b1;
          state_next   = ST_EXEC;
        end
      end
      ST_EXEC: begin
        load_rsp   = 1'b1;
        state_next = ST_IDLE;
        case (op_q)
          OP_ADD: begin
            if (!any_match) begin
              if (full) begin
                res_status = STAT_FULL;
              end else begin
                ctrl.add_go = 1'b1;
                count_next  = count + CNT_W'(1);
                res_hit     = 1'b1;
              end
            end
            res_count = 7'(count_next);
          end
          OP_CONTAINS: begin
            res_hit = any_match;
          end
          OP_REMOVE: begin
            if (any_match) begin
              ctrl.remove_go = 1'b1;
              count_next     = count - CNT_W'(1);
              res_hit        = 1'b1;
            end
            res_count = 7'(count_next);
          end
          OP_GET: begin
            if (in_range) begin
              res_value = cell_value[rd_idx];
            end else begin
              res_status = STAT_RANGE;
            end
          end
          OP_CLEAR: begin
            ctrl.clear_go = 1'b1;
            count_next    = '0;
          end
          default: begin
          end
        endcase
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      count <= count_next;
    end
  end

  // Output register: holds the response until its transfer completes.
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (load_rsp) begin
      rsp.valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_rsp) begin
      rsp.hit        <= res_hit;
      rsp.read_value <= $signed(res_value);
      rsp.count      <= res_count;
      rsp.status     <= res_status;
    end
  end

  // The occupied flags always agree with the entry counter.
  `ASSERT_IMPLIES(a_occ_count, clk, rst, 1'b1, $countones(cell_occ) == 32'(count))
  // The counter never exceeds the capacity.
  `ASSERT_IMPLIES(a_count_cap, clk, rst, 1'b1, 32'(count) <= 32'(CAPACITY))
  // The resolve cycle always produces a response in the next cycle.
  `ASSERT_NEXT(a_exec_rsp, clk, rst, state == ST_EXEC, rsp.valid)
  // A full status is only reported with a full set.
  `ASSERT_IMPLIES(a_full_count, clk, rst, rsp.valid && (rsp.status == STAT_FULL),
                  rsp.count == 7'(CAPACITY))

endmodule
`default_nettype wire
